// ===== hw/rtl/cga_pkg.sv =====
package cga_pkg;

  localparam int GENES_W    = 64;
  localparam int FIT_W      = 7;
  localparam int COORD_W    = 4;
  localparam int DIM_W      = 7;
  localparam int CUT_W      = 6;
  localparam int DRAW_W     = 16;
  localparam int THR_W      = 17;
  localparam int GRID_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_ROWS      = 2'd1;
  localparam cfg_idx_t CFG_COLS      = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 17'd6554;
  localparam logic [GRID_W-1:0] GRID_RESET      = 5'd16;

  typedef enum logic [1:0] {
    ACT_LOAD,
    ACT_EVOLVE,
    ACT_COMMIT,
    ACT_READ
  } action_t;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PARENTS,
    ST_OWN,
    ST_FINISH
  } cga_state_t;

  typedef struct packed {
    action_t              action;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   column;
    logic [GENES_W-1:0]   genes;
    dir_t                 dir_first;
    dir_t                 dir_second;
    logic [CUT_W-1:0]     cut_point;
    logic [DRAW_W-1:0]    mutate_draw;
    logic [CUT_W-1:0]     mutate_position;
  } cga_req_t;

  typedef struct packed {
    logic                 status;
    logic [FIT_W-1:0]     child_fitness;
    logic                 replaced;
    logic [FIT_W-1:0]     best_fitness;
    logic [GENES_W-1:0]   best_genes;
  } cga_rsp_t;

  typedef struct packed {
    logic             off;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
  } nbr_t;

endpackage

// ===== hw/rtl/cga_ram.sv =====
module cga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/cellular_ga_onemax_cell_update.sv =====
// Cell engine of a cellular genetic algorithm for OneMax. Individuals live in two banks
// of one synchronous memory (kept as two identical copies so both parents are read in
// the same cycle); commit swaps the banks. A request is taken when start is high and
// busy is low, and exactly one result follows on out_rsp with out_valid high for one
// cycle; the receiver cannot stall it. Load, commit, read, ignored and retry requests
// pass through the finish state alone. Evolve runs the parent read, then the read of
// the cell itself on the same memory port, then the compare and write-back into the
// other bank. busy holds off new requests until the result is shown, so no access
// can overlap a pending write. Every cell must be evolved once per generation.
module cellular_ga_onemax_cell_update
  import cga_pkg::*;
#(
  parameter int GENE_BITS = 64,
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  cga_req_t              in_req,
  output logic                  out_valid,
  output cga_rsp_t              out_rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int DEPTH  = 2 * CELLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = FIT_W + GENE_BITS;

  function automatic logic [AW-1:0] slot(input logic bank, input logic [DIM_W-1:0] r,
                                         input logic [DIM_W-1:0] c);
    logic [AW-1:0] base;
    base = bank ? AW'(CELLS) : '0;
    return base + AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  function automatic nbr_t step(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                                input dir_t d, input logic [DIM_W-1:0] nr,
                                input logic [DIM_W-1:0] nc);
    nbr_t n;
    n.r   = r;
    n.c   = c;
    n.off = 1'b0;
    case (d)
      DIR_UP: begin
        n.off = (r == '0);
        n.r   = r - DIM_W'(1);
      end
      DIR_DOWN: begin
        n.r   = r + DIM_W'(1);
        n.off = (n.r >= nr);
      end
      DIR_LEFT: begin
        n.off = (c == '0);
        n.c   = c - DIM_W'(1);
      end
      DIR_RIGHT: begin
        n.c   = c + DIM_W'(1);
        n.off = (n.c >= nc);
      end
      default: n.off = 1'b1;
    endcase
    return n;
  endfunction

  function automatic logic [FIT_W-1:0] ones(input logic [GENE_BITS-1:0] v);
    logic [FIT_W-1:0] n;
    n = '0;
    for (int i = 0; i < GENE_BITS; i++) begin
      n = n + FIT_W'(v[i]);
    end
    return n;
  endfunction

  // configuration
  logic [THR_W-1:0]  thr_r;
  logic [GRID_W-1:0] rows_r;
  logic [GRID_W-1:0] cols_r;
  logic [DIM_W-1:0]  nrows;
  logic [DIM_W-1:0]  ncols;

  // control and state
  cga_state_t           state_r, state_nxt;
  logic                 bank_r, bank_nxt;
  logic [GENE_BITS-1:0] best_genes_r, best_genes_nxt;
  logic [FIT_W-1:0]     best_fit_r, best_fit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cga_rsp_t             out_rsp_r, out_rsp_nxt;

  // captured request
  cga_req_t             req_r;
  logic                 on_grid_r;
  logic                 retry_r;
  logic [GENE_BITS-1:0] child_r, child_nxt;

  // decode at accept
  logic             accept;
  logic [DIM_W-1:0] in_row;
  logic [DIM_W-1:0] in_col;
  logic             in_on_grid;
  nbr_t             nbr_a;
  nbr_t             nbr_b;
  logic             in_evolve;
  logic             in_retry;

  // memory ports
  logic [AW-1:0]     rd_a_addr;
  logic [AW-1:0]     rd_b_addr;
  logic [WORD_W-1:0] rd_a_data;
  logic [WORD_W-1:0] rd_b_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [DIM_W-1:0]     req_row;
  logic [DIM_W-1:0]     req_col;
  logic [GENE_BITS-1:0] pc_in;
  logic [FIT_W-1:0]     fit;
  logic                 mutate;
  logic                 better;

  assign nrows = (DIM_W'(rows_r) < DIM_W'(MAX_ROWS)) ? DIM_W'(rows_r) : DIM_W'(MAX_ROWS);
  assign ncols = (DIM_W'(cols_r) < DIM_W'(MAX_COLS)) ? DIM_W'(cols_r) : DIM_W'(MAX_COLS);

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign in_row     = DIM_W'(in_req.row);
  assign in_col     = DIM_W'(in_req.column);
  assign in_on_grid = (in_row < nrows) && (in_col < ncols);
  assign nbr_a      = step(in_row, in_col, in_req.dir_first, nrows, ncols);
  assign nbr_b      = step(in_row, in_col, in_req.dir_second, nrows, ncols);
  assign in_retry   = (in_req.action == ACT_EVOLVE) && in_on_grid && (nbr_a.off || nbr_b.off);
  assign in_evolve  = (in_req.action == ACT_EVOLVE) && in_on_grid && !nbr_a.off && !nbr_b.off;

  assign req_row = DIM_W'(req_r.row);
  assign req_col = DIM_W'(req_r.column);

  // crossover and mutation on the parents as they come out of memory
  assign mutate = ({1'b0, req_r.mutate_draw} < thr_r);

  always_comb begin
    for (int i = 0; i < GENE_BITS; i++) begin
      child_nxt[i] = ((DIM_W'(i) < DIM_W'(req_r.cut_point)) ? rd_a_data[i] : rd_b_data[i])
                     ^ (mutate && (DIM_W'(i) == DIM_W'(req_r.mutate_position)));
    end
  end

  // one ones-counter shared by load and evolve
  assign pc_in = (state_r == ST_OWN) ? child_r : req_r.genes[GENE_BITS-1:0];
  assign fit   = ones(pc_in);
  assign better = (fit > rd_a_data[WORD_W-1:GENE_BITS]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_evolve ? ST_PARENTS : ST_FINISH;
        end
      end
      ST_PARENTS: state_nxt = ST_OWN;
      ST_OWN:     state_nxt = ST_IDLE;
      ST_FINISH:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_a_addr      = slot(bank_r, nbr_a.r, nbr_a.c);
    rd_b_addr      = slot(bank_r, nbr_b.r, nbr_b.c);
    wr_en          = 1'b0;
    wr_addr        = slot(~bank_r, req_row, req_col);
    wr_data        = rd_a_data;
    bank_nxt       = bank_r;
    best_genes_nxt = best_genes_r;
    best_fit_nxt   = best_fit_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = '0;
    case (state_r)
      ST_PARENTS: begin
        rd_a_addr = slot(bank_r, req_row, req_col);
      end
      ST_OWN: begin
        // next bank gets the child only if strictly fitter, else the cell itself
        wr_en = 1'b1;
        if (better) begin
          wr_data = {fit, child_r};
          if (fit > best_fit_r) begin
            best_genes_nxt = child_r;
            best_fit_nxt   = fit;
          end
        end
        out_valid_nxt             = 1'b1;
        out_rsp_nxt.child_fitness = fit;
        out_rsp_nxt.replaced      = better;
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        case (req_r.action)
          ACT_LOAD: begin
            if (on_grid_r) begin
              wr_en                     = 1'b1;
              wr_addr                   = slot(bank_r, req_row, req_col);
              wr_data                   = {fit, req_r.genes[GENE_BITS-1:0]};
              out_rsp_nxt.child_fitness = fit;
              // loading the origin cell always restarts the best
              if ((req_r.row == '0 && req_r.column == '0) || fit > best_fit_r) begin
                best_genes_nxt = req_r.genes[GENE_BITS-1:0];
                best_fit_nxt   = fit;
              end
            end
          end
          ACT_EVOLVE: out_rsp_nxt.status = retry_r;
          ACT_COMMIT: bank_nxt = ~bank_r;
          ACT_READ:   ;
          default:    ;
        endcase
      end
      default: ;
    endcase
    out_rsp_nxt.best_fitness = best_fit_nxt;
    out_rsp_nxt.best_genes   = GENES_W'(best_genes_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RESET;
      rows_r <= GRID_RESET;
      cols_r <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        CFG_ROWS:      rows_r <= cfg_data[GRID_W-1:0];
        CFG_COLS:      cols_r <= cfg_data[GRID_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bank_r       <= 1'b0;
      best_genes_r <= '0;
      best_fit_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bank_r       <= bank_nxt;
      best_genes_r <= best_genes_nxt;
      best_fit_r   <= best_fit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_req;
      on_grid_r <= in_on_grid;
      retry_r   <= in_retry;
    end
    if (state_r == ST_PARENTS) begin
      child_r <= child_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  cga_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_a_addr),
    .rd_data (rd_a_data)
  );

  cga_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_b_addr),
    .rd_data (rd_b_data)
  );

endmodule

// ===== hw/rtl/cga_checker.sv =====
module cga_checker
  import cga_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input cga_rsp_t out_rsp
);

  // an accepted request always raises busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  // the engine frees up exactly when it reports
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("engine went idle without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while engine still busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a retry changes nothing; a replacement needs a nonzero child
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status) |-> (!out_rsp.replaced && out_rsp.child_fitness == '0))
    else $error("retry result carries child data");

endmodule

bind cellular_ga_onemax_cell_update cga_checker u_cga_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
